/* hw/rtl/whp_pkg.sv */
// whp_pkg: shared constants for the wav header parser
// chunk tags, status codes and sample format codes
// no dependencies
package whp_pkg;

  // four-character tags as seen little-endian in a 32-bit shift register
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_TAG         = 16'd1;
  localparam logic [15:0] SIGNED_MIN_BITS = 16'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE = 3'd2;
  localparam logic [2:0] ST_NOT_PCM  = 3'd3;
  localparam logic [2:0] ST_MISSING  = 3'd4;

  localparam logic [2:0] FMT_S8    = 3'd0;
  localparam logic [2:0] FMT_S16   = 3'd1;
  localparam logic [2:0] FMT_U8    = 3'd2;
  localparam logic [2:0] FMT_U16   = 3'd3;
  localparam logic [2:0] FMT_OTHER = 3'd4;

endpackage

/* hw/rtl/wav_header_parser_unit.sv */
// wav_header_parser_unit: byte-serial RIFF/WAVE PCM header parser
// uses whp_pkg; contains the chunk walker and one shared restoring divider
// reports one result per file
//
// The parser takes one file byte per cycle while it walks the header. When the
// length field of the data chunk completes, the input stalls while one shared
// restoring divider, one quotient bit per cycle, first works out bytes per
// sample and then, after a multiply step, the frame count. Error results are
// ready in the cycle after the offending byte. The input also stalls while a
// result waits to be taken. Bytes after a result are accepted and dropped
// until a byte marked first_byte starts a new file.
module wav_header_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        end_of_file,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [15:0] bits_per_sample,
  output logic [15:0] bytes_per_sample,
  output logic [2:0]  sample_format,
  output logic [31:0] data_length,
  output logic [31:0] sample_frames,
  output logic [31:0] data_offset
);

  typedef enum logic [9:0] {
    PH_RIFF     = 10'b00_0000_0001,
    PH_RLEN     = 10'b00_0000_0010,
    PH_WAVE     = 10'b00_0000_0100,
    PH_ID       = 10'b00_0000_1000,
    PH_LEN_FMT  = 10'b00_0001_0000,
    PH_LEN_DATA = 10'b00_0010_0000,
    PH_LEN_SKIP = 10'b00_0100_0000,
    PH_FMT      = 10'b00_1000_0000,
    PH_SKIP     = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [3:0] {
    CTL_PARSE = 4'b0001,
    CTL_DIV1  = 4'b0010,
    CTL_MUL   = 4'b0100,
    CTL_DIV2  = 4'b1000
  } ctl_t;

  // byte counts inside the fmt body at which a field completes
  localparam logic [4:0] FMT_TAG_END   = 5'd2;
  localparam logic [4:0] FMT_CH_END    = 5'd4;
  localparam logic [4:0] FMT_RATE_END  = 5'd8;
  localparam logic [4:0] FMT_ALIGN_END = 5'd14;
  localparam logic [4:0] FMT_BITS_END  = 5'd16;

  phase_t      phase, phase_next, c_phase;
  ctl_t        ctl;
  logic [4:0]  cnt, cnt_next, c_cnt;
  logic [31:0] shift, shift_next, c_shift;
  logic [31:0] clen, clen_next, c_clen;
  logic [31:0] fpos, fpos_next, c_fpos;
  logic [15:0] ftag, ftag_next, c_ftag;
  logic [15:0] ch, ch_next, c_ch;
  logic [31:0] rate, rate_next, c_rate;
  logic [15:0] align, align_next, c_align;
  logic [15:0] bits, bits_next, c_bits;
  logic        fmt_seen, fmt_seen_next, c_fmt_seen;
  logic        done, done_next, c_done;
  logic        word_done;
  logic        emit_err, emit_ok;
  logic [2:0]  err_code;
  logic        accept;

  // shared divider
  logic [16:0] div_rem;
  logic [31:0] div_quo;
  logic [15:0] div_dvs;
  logic [4:0]  div_step;
  logic [16:0] rem_sh, rem_step;
  logic [31:0] quo_step;
  logic        fits;
  logic [15:0] bps;
  logic [31:0] prod;
  logic [2:0]  fmt_code;

  assign item_stall = (ctl != CTL_PARSE) || result_valid;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    c_phase    = first_byte ? PH_RIFF : phase;
    c_cnt      = first_byte ? 5'd0 : cnt;
    c_shift    = first_byte ? 32'd0 : shift;
    c_clen     = first_byte ? 32'd0 : clen;
    c_fpos     = first_byte ? 32'd0 : fpos;
    c_ftag     = first_byte ? 16'd0 : ftag;
    c_ch       = first_byte ? 16'd0 : ch;
    c_rate     = first_byte ? 32'd0 : rate;
    c_align    = first_byte ? 16'd0 : align;
    c_bits     = first_byte ? 16'd0 : bits;
    c_fmt_seen = first_byte ? 1'b0 : fmt_seen;
    c_done     = first_byte ? 1'b0 : done;

    phase_next    = c_phase;
    cnt_next      = c_cnt;
    shift_next    = c_shift;
    clen_next     = c_clen;
    fpos_next     = c_fpos;
    ftag_next     = c_ftag;
    ch_next       = c_ch;
    rate_next     = c_rate;
    align_next    = c_align;
    bits_next     = c_bits;
    fmt_seen_next = c_fmt_seen;
    done_next     = c_done;
    emit_err      = 1'b0;
    emit_ok       = 1'b0;
    err_code      = whp_pkg::ST_OK;
    word_done     = (c_cnt + 5'd1) >= 5'd4;

    if (!c_done) begin
      fpos_next  = c_fpos + 32'd1;
      shift_next = {data_byte, c_shift[31:8]};
      cnt_next   = c_cnt + 5'd1;
      unique case (c_phase)
        PH_RIFF: begin
          if (word_done) begin
            if (shift_next != whp_pkg::TAG_RIFF) begin
              emit_err = 1'b1;
              err_code = whp_pkg::ST_NOT_RIFF;
            end else begin
              phase_next = PH_RLEN;
              cnt_next   = 5'd0;
            end
          end
        end
        PH_RLEN: begin
          if (word_done) begin
            phase_next = PH_WAVE;
            cnt_next   = 5'd0;
          end
        end
        PH_WAVE: begin
          if (word_done) begin
            if (shift_next != whp_pkg::TAG_WAVE) begin
              emit_err = 1'b1;
              err_code = whp_pkg::ST_NOT_WAVE;
            end else begin
              phase_next = PH_ID;
              cnt_next   = 5'd0;
            end
          end
        end
        PH_ID: begin
          if (word_done) begin
            cnt_next = 5'd0;
            priority if (shift_next == whp_pkg::TAG_FMT) phase_next = PH_LEN_FMT;
            else if (shift_next == whp_pkg::TAG_DATA) phase_next = PH_LEN_DATA;
            else phase_next = PH_LEN_SKIP;
          end
        end
        PH_LEN_FMT: begin
          if (word_done) begin
            clen_next     = shift_next;
            fmt_seen_next = 1'b1;
            phase_next    = PH_FMT;
            cnt_next      = 5'd0;
          end
        end
        PH_LEN_DATA: begin
          if (word_done) begin
            clen_next = shift_next;
            if (!c_fmt_seen) begin
              emit_err = 1'b1;
              err_code = whp_pkg::ST_MISSING;
            end else begin
              emit_ok = 1'b1;
            end
          end
        end
        PH_LEN_SKIP: begin
          if (word_done) begin
            clen_next  = shift_next;
            phase_next = (shift_next != 32'd0) ? PH_SKIP : PH_ID;
            cnt_next   = 5'd0;
          end
        end
        PH_FMT: begin
          unique case (cnt_next)
            FMT_TAG_END:   ftag_next  = shift_next[31:16];
            FMT_CH_END:    ch_next    = shift_next[31:16];
            FMT_RATE_END:  rate_next  = shift_next;
            FMT_ALIGN_END: align_next = shift_next[31:16];
            FMT_BITS_END: begin
              bits_next = shift_next[31:16];
              if (c_ftag != whp_pkg::PCM_TAG) begin
                emit_err = 1'b1;
                err_code = whp_pkg::ST_NOT_PCM;
              end else if (c_clen > 32'd16) begin
                clen_next  = c_clen - 32'd16;
                phase_next = PH_SKIP;
                cnt_next   = 5'd0;
              end else begin
                phase_next = PH_ID;
                cnt_next   = 5'd0;
              end
            end
            default: ;
          endcase
        end
        PH_SKIP: begin
          cnt_next = 5'd0;
          if (c_clen != 32'd0) clen_next = c_clen - 32'd1;
          if (c_clen <= 32'd1) phase_next = PH_ID;
        end
        PH_DONE: begin
          phase_next = PH_ID;
          cnt_next   = 5'd0;
        end
        default: ;
      endcase

      // early end of file
      if (end_of_file && !emit_err && !emit_ok) begin
        emit_err = 1'b1;
        priority if (phase_next == PH_RIFF) err_code = whp_pkg::ST_NOT_RIFF;
        else if (phase_next == PH_RLEN || phase_next == PH_WAVE)
          err_code = whp_pkg::ST_NOT_WAVE;
        else err_code = whp_pkg::ST_MISSING;
      end
      if (emit_err || emit_ok) begin
        done_next  = 1'b1;
        phase_next = PH_DONE;
      end
    end
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {div_rem[15:0], div_quo[31]};
    fits     = rem_sh >= {1'b0, div_dvs};
    rem_step = fits ? (rem_sh - {1'b0, div_dvs}) : rem_sh;
    quo_step = {div_quo[30:0], fits};
  end

  assign prod = bps * ch;

  always_comb begin
    unique case (bps)
      16'd1:   fmt_code = (bits >= whp_pkg::SIGNED_MIN_BITS) ? whp_pkg::FMT_S8
                                                             : whp_pkg::FMT_U8;
      16'd2:   fmt_code = (bits >= whp_pkg::SIGNED_MIN_BITS) ? whp_pkg::FMT_S16
                                                             : whp_pkg::FMT_U16;
      default: fmt_code = whp_pkg::FMT_OTHER;
    endcase
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_RIFF;
      cnt      <= 5'd0;
      shift    <= 32'd0;
      clen     <= 32'd0;
      fpos     <= 32'd0;
      ftag     <= 16'd0;
      ch       <= 16'd0;
      rate     <= 32'd0;
      align    <= 16'd0;
      bits     <= 16'd0;
      fmt_seen <= 1'b0;
      done     <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      cnt      <= cnt_next;
      shift    <= shift_next;
      clen     <= clen_next;
      fpos     <= fpos_next;
      ftag     <= ftag_next;
      ch       <= ch_next;
      rate     <= rate_next;
      align    <= align_next;
      bits     <= bits_next;
      fmt_seen <= fmt_seen_next;
      done     <= done_next;
    end
  end

  // sequencer for the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= CTL_PARSE;
    end else begin
      unique case (ctl)
        CTL_PARSE: if (accept && emit_ok) ctl <= CTL_DIV1;
        CTL_DIV1:  if (div_step == 5'd0) ctl <= CTL_MUL;
        CTL_MUL:   ctl <= CTL_DIV2;
        CTL_DIV2:  if (div_step == 5'd0) ctl <= CTL_PARSE;
        default:   ctl <= CTL_PARSE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl)
      CTL_PARSE: begin
        // block align sits in the upper half so 16 steps give the quotient
        div_quo  <= {align_next, 16'd0};
        div_rem  <= 17'd0;
        div_dvs  <= ch_next;
        div_step <= 5'd15;
      end
      CTL_DIV1: begin
        div_quo  <= quo_step;
        div_rem  <= rem_step;
        div_step <= div_step - 5'd1;
        if (div_step == 5'd0) bps <= (div_dvs == 16'd0) ? 16'd0 : quo_step[15:0];
      end
      CTL_MUL: begin
        // bps * channels never exceeds block align
        div_dvs  <= prod[15:0];
        div_quo  <= clen;
        div_rem  <= 17'd0;
        div_step <= 5'd31;
      end
      CTL_DIV2: begin
        div_quo  <= quo_step;
        div_rem  <= rem_step;
        div_step <= div_step - 5'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end else if ((accept && emit_err) || (ctl == CTL_DIV2 && div_step == 5'd0)) begin
      result_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_err) begin
      status           <= err_code;
      channel_count    <= 16'd0;
      sample_rate      <= 32'd0;
      bits_per_sample  <= 16'd0;
      bytes_per_sample <= 16'd0;
      sample_format    <= 3'd0;
      data_length      <= 32'd0;
      sample_frames    <= 32'd0;
      data_offset      <= 32'd0;
    end else if (ctl == CTL_DIV2 && div_step == 5'd0) begin
      status           <= whp_pkg::ST_OK;
      channel_count    <= ch;
      sample_rate      <= rate;
      bits_per_sample  <= bits;
      bytes_per_sample <= bps;
      sample_format    <= fmt_code;
      data_length      <= clen;
      sample_frames    <= (div_dvs == 16'd0) ? 32'd0 : quo_step;
      data_offset      <= fpos;
    end
  end

endmodule

/* hw/rtl/whp_checker.sv */
// whp_checker: port-level assertions for wav_header_parser_unit
// uses whp_pkg; bound to wav_header_parser_unit at the end of this file
module whp_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic [15:0] channel_count,
  input logic [15:0] bytes_per_sample,
  input logic [2:0]  sample_format,
  input logic [31:0] data_length,
  input logic [31:0] sample_frames,
  input logic [31:0] data_offset
);

  // a waiting result holds through a stall
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status)
      && $stable(data_length) && $stable(sample_frames))
    else $error("result changed while stalled");

  // no new byte taken while a result waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input open while a result waits");

  // error results carry only a status
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != whp_pkg::ST_OK |-> channel_count == 16'd0
      && data_length == 32'd0 && sample_frames == 32'd0 && data_offset == 32'd0)
    else $error("error result with payload");

  // format code follows bytes per sample
  a_fmt: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == whp_pkg::ST_OK && bytes_per_sample != 16'd1
      && bytes_per_sample != 16'd2 |-> sample_format == whp_pkg::FMT_OTHER)
    else $error("bad sample format code");

endmodule

bind wav_header_parser_unit whp_checker u_whp_checker (
  .clk              (clk),
  .rst              (rst),
  .item_stall       (item_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .status           (status),
  .channel_count    (channel_count),
  .bytes_per_sample (bytes_per_sample),
  .sample_format    (sample_format),
  .data_length      (data_length),
  .sample_frames    (sample_frames),
  .data_offset      (data_offset)
);
